/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define TSFS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsfs: check failed");

// Next-cycle implication, disabled while rst is high.
`define TSFS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsfs: check failed");

`endif

/* hw/rtl/tsfs_pkg.sv */
// Package with the types and constants of the touch sample filter and scale unit.
`default_nettype none

package tsfs_pkg;

   localparam int SampleW    = 12;
   localparam int PressureW  = 13;
   localparam int IntervalW  = 8;
   localparam int TimeW      = 32;
   localparam int XPosW      = 9;
   localparam int YPosW      = 8;

   typedef logic [SampleW-1:0]   sample_type;
   typedef logic [PressureW-1:0] pressure_type;
   typedef logic [TimeW-1:0]     time_type;
   typedef logic [XPosW-1:0]     x_pos_type;
   typedef logic [YPosW-1:0]     y_pos_type;

   typedef enum logic [1:0] {
      CSR_PRESSURE_THRESHOLD = 2'd0,
      CSR_MIN_INTERVAL_MS    = 2'd1,
      CSR_USE_PEN_IRQ        = 2'd2,
      CSR_ROTATE             = 2'd3
   } csr_index_type;

   localparam pressure_type        PRESSURE_THRESHOLD_RESET = 13'd400;
   localparam logic [IntervalW-1:0] MIN_INTERVAL_RESET      = 8'd3;
   localparam time_type            LAST_TOUCH_RESET         = 32'h8000_0000;
   localparam pressure_type        Z_OFFSET                 = 13'd4095;

   localparam sample_type X_IN_LO = 12'd230;
   localparam sample_type Y_IN_LO = 12'd230;
   localparam x_pos_type  X_SPAN  = 9'd320;
   localparam y_pos_type  Y_SPAN  = 8'd240;
   localparam x_pos_type  X_MAX   = 9'd319;
   localparam y_pos_type  Y_MAX   = 8'd239;

   // The X scale 320 / (3670 - 230) reduces to 4 / 43, the Y scale 240 / (3800 - 230)
   // to 8 / 119. Both divisions are done by a rounded-up reciprocal, exact over the
   // whole range of the numerators.
   localparam int XNumW   = SampleW + 2;
   localparam int YNumW   = SampleW + 3;
   localparam int XRecipW = 15;
   localparam int YRecipW = 16;
   localparam int XShift  = 20;
   localparam int YShift  = 22;
   localparam logic [XRecipW-1:0] X_RECIP = 15'd24386;
   localparam logic [YRecipW-1:0] Y_RECIP = 16'd35247;

endpackage

`default_nettype wire

/* hw/rtl/tsfs_if.sv */
// Request and response channel interfaces of the touch sample filter and scale unit.
`default_nettype none

interface tsfs_req_if import tsfs_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type pressure_first;
   sample_type pressure_second;
   sample_type x_sample_a;
   sample_type x_sample_b;
   sample_type x_sample_c;
   sample_type y_sample_a;
   sample_type y_sample_b;
   sample_type y_sample_c;
   time_type   time_ms;
   logic       pen_irq;

   modport source (
      output valid, pressure_first, pressure_second, x_sample_a, x_sample_b, x_sample_c,
             y_sample_a, y_sample_b, y_sample_c, time_ms, pen_irq,
      input  ready
   );
   modport sink (
      input  valid, pressure_first, pressure_second, x_sample_a, x_sample_b, x_sample_c,
             y_sample_a, y_sample_b, y_sample_c, time_ms, pen_irq,
      output ready
   );
endinterface

interface tsfs_rsp_if import tsfs_pkg::*; ();
   logic         valid;
   logic         ready;
   x_pos_type    x_pos;
   y_pos_type    y_pos;
   pressure_type pressure;
   logic         touched;
   logic         sampled;

   modport source (
      output valid, x_pos, y_pos, pressure, touched, sampled,
      input  ready
   );
   modport sink (
      input  valid, x_pos, y_pos, pressure, touched, sampled,
      output ready
   );
endinterface

`default_nettype wire

/* hw/rtl/touch_sample_filter_and_scale_unit.sv */
// Top level of the touch sample filter and scale unit.
// Takes one conversion set per clock cycle while the response side is not stalled, and
// returns one result beat for each from the result register. The set is first
// captured in an input register; the gating, pressure check, closest-two filtering and
// screen mapping then run in a single combinational pass into the result register,
// which also updates the held state. A stalled result holds the result register, and
// the input register still takes one more beat behind it.
`default_nettype none

module touch_sample_filter_and_scale_unit import tsfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tsfs_req_if.sink             req_chan,
   tsfs_rsp_if.source           rsp_chan,
   input  logic                 csr_wr_en,
   input  csr_index_type        csr_index,
   input  logic [PressureW-1:0] csr_wr_data
);

   typedef struct packed {
      sample_type pressure_first;
      sample_type pressure_second;
      sample_type x_sample_a;
      sample_type x_sample_b;
      sample_type x_sample_c;
      sample_type y_sample_a;
      sample_type y_sample_b;
      sample_type y_sample_c;
      time_type   time_ms;
      logic       pen_irq;
   } item_type;

   typedef struct packed {
      pressure_type         pressure_threshold;
      logic [IntervalW-1:0] min_interval_ms;
      logic                 use_pen_irq;
      logic                 rotate;
   } cfg_type;

   typedef struct packed {
      x_pos_type    held_x;
      y_pos_type    held_y;
      pressure_type held_pressure;
      time_type     last_touch_ms;
      logic         awake;
   } state_type;

   typedef struct packed {
      x_pos_type    x_pos;
      y_pos_type    y_pos;
      pressure_type pressure;
      logic         touched;
      logic         sampled;
   } result_type;

   item_type   item_ff,      item_in;
   logic       in_valid_ff,  in_valid_in;
   result_type rsp_ff,       rsp_in;
   logic       out_valid_ff, out_valid_in;
   cfg_type    cfg_ff,       cfg_in;
   state_type  state_ff,     state_in;

   logic         advance;
   logic         fire;
   logic         awake_now;
   logic         evaluate;
   logic         release_seen;
   time_type     elapsed;
   pressure_type pressure_now;
   sample_type   x_mean;
   sample_type   y_mean;
   x_pos_type    x_mapped;
   y_pos_type    y_mapped;

   tsfs_mean3 u_x_mean (
      .sample_a (item_ff.x_sample_a),
      .sample_b (item_ff.x_sample_b),
      .sample_c (item_ff.x_sample_c),
      .mean     (x_mean)
   );

   tsfs_mean3 u_y_mean (
      .sample_a (item_ff.y_sample_a),
      .sample_b (item_ff.y_sample_b),
      .sample_c (item_ff.y_sample_c),
      .mean     (y_mean)
   );

   tsfs_scale u_scale (
      .x_mean (x_mean),
      .y_mean (y_mean),
      .x_pos  (x_mapped),
      .y_pos  (y_mapped)
   );

   always_comb begin
      advance        = !out_valid_ff || rsp_chan.ready;
      fire           = in_valid_ff && advance;
      req_chan.ready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         item_in     = '{
            pressure_first:  req_chan.pressure_first,
            pressure_second: req_chan.pressure_second,
            x_sample_a:      req_chan.x_sample_a,
            x_sample_b:      req_chan.x_sample_b,
            x_sample_c:      req_chan.x_sample_c,
            y_sample_a:      req_chan.y_sample_a,
            y_sample_b:      req_chan.y_sample_b,
            y_sample_c:      req_chan.y_sample_c,
            time_ms:         req_chan.time_ms,
            pen_irq:         req_chan.pen_irq
         };
      end

      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESSURE_THRESHOLD: begin
               cfg_in.pressure_threshold = csr_wr_data;
            end
            CSR_MIN_INTERVAL_MS: begin
               cfg_in.min_interval_ms = csr_wr_data[IntervalW-1:0];
            end
            CSR_USE_PEN_IRQ: begin
               cfg_in.use_pen_irq = csr_wr_data[0];
            end
            CSR_ROTATE: begin
               cfg_in.rotate = csr_wr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end

      awake_now    = item_ff.pen_irq || !cfg_ff.use_pen_irq || state_ff.awake;
      elapsed      = item_ff.time_ms - state_ff.last_touch_ms;
      evaluate     = awake_now && (elapsed >= TimeW'(cfg_ff.min_interval_ms));
      pressure_now = {1'b0, item_ff.pressure_first} + Z_OFFSET
                     - {1'b0, item_ff.pressure_second};
      release_seen = pressure_now < cfg_ff.pressure_threshold;

      state_in       = state_ff;
      state_in.awake = awake_now;
      if (evaluate) begin
         if (release_seen) begin
            state_in.held_pressure = '0;
            if (cfg_ff.use_pen_irq) begin
               state_in.awake = 1'b0;
            end
         end else begin
            state_in.held_pressure = pressure_now;
            state_in.last_touch_ms = item_ff.time_ms;
            state_in.held_x        = x_mapped;
            state_in.held_y        = y_mapped;
         end
      end

      rsp_in.x_pos    = cfg_ff.rotate ? X_SPAN - state_in.held_x : state_in.held_x;
      rsp_in.y_pos    = cfg_ff.rotate ? Y_SPAN - state_in.held_y : state_in.held_y;
      rsp_in.pressure = state_in.held_pressure;
      rsp_in.touched  = state_in.held_pressure >= cfg_ff.pressure_threshold;
      rsp_in.sampled  = evaluate;

      if (!fire) begin
         state_in = state_ff;
         rsp_in   = rsp_ff;
      end

      out_valid_in = advance ? in_valid_ff : out_valid_ff;

      rsp_chan.valid    = out_valid_ff;
      rsp_chan.x_pos    = rsp_ff.x_pos;
      rsp_chan.y_pos    = rsp_ff.y_pos;
      rsp_chan.pressure = rsp_ff.pressure;
      rsp_chan.touched  = rsp_ff.touched;
      rsp_chan.sampled  = rsp_ff.sampled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '{
            pressure_threshold: PRESSURE_THRESHOLD_RESET,
            min_interval_ms:    MIN_INTERVAL_RESET,
            use_pen_irq:        1'b0,
            rotate:             1'b0
         };
         state_ff     <= '{
            held_x:        '0,
            held_y:        '0,
            held_pressure: '0,
            last_touch_ms: LAST_TOUCH_RESET,
            awake:         1'b1
         };
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/tsfs_mean3.sv */
// Mean of the closest two of three position samples.
`default_nettype none

module tsfs_mean3 import tsfs_pkg::*; (
   input  sample_type sample_a,
   input  sample_type sample_b,
   input  sample_type sample_c,
   output sample_type mean
);

   sample_type         diff_ab;
   sample_type         diff_ac;
   sample_type         diff_bc;
   logic [SampleW:0]   pair_sum;

   always_comb begin
      diff_ab = (sample_a > sample_b) ? sample_a - sample_b : sample_b - sample_a;
      diff_ac = (sample_a > sample_c) ? sample_a - sample_c : sample_c - sample_a;
      diff_bc = (sample_b > sample_c) ? sample_b - sample_c : sample_c - sample_b;
      // Ties go to the earlier pair in the order ab, ac, bc.
      if (diff_ab <= diff_ac && diff_ab <= diff_bc) begin
         pair_sum = {1'b0, sample_a} + {1'b0, sample_b};
      end else if (diff_ac <= diff_bc) begin
         pair_sum = {1'b0, sample_a} + {1'b0, sample_c};
      end else begin
         pair_sum = {1'b0, sample_b} + {1'b0, sample_c};
      end
      mean = pair_sum[SampleW:1];
   end

endmodule

`default_nettype wire

/* hw/rtl/tsfs_scale.sv */
// Linear mapping of the filtered X and Y readings to clamped screen coordinates.
`default_nettype none

module tsfs_scale import tsfs_pkg::*; (
   input  sample_type x_mean,
   input  sample_type y_mean,
   output x_pos_type  x_pos,
   output y_pos_type  y_pos
);

   localparam int XProdW = XNumW + XRecipW;
   localparam int YProdW = YNumW + YRecipW;

   sample_type          x_off;
   sample_type          y_off;
   logic [XNumW-1:0]    x_num;
   logic [YNumW-1:0]    y_num;
   logic [XProdW-1:0]   x_prod;
   logic [YProdW-1:0]   y_prod;
   x_pos_type           x_quot;
   logic [XPosW-1:0]    y_quot;

   always_comb begin
      x_off  = x_mean - X_IN_LO;
      y_off  = y_mean - Y_IN_LO;
      x_num  = {x_off, 2'b00};
      y_num  = {y_off, 3'b000};
      x_prod = XProdW'(x_num) * XProdW'(X_RECIP);
      y_prod = YProdW'(y_num) * YProdW'(Y_RECIP);
      x_quot = x_prod[XProdW-1:XShift];
      y_quot = y_prod[YProdW-1:YShift];

      if (x_mean < X_IN_LO) begin
         x_pos = '0;
      end else if (x_quot > X_MAX) begin
         x_pos = X_MAX;
      end else begin
         x_pos = x_quot;
      end

      // The Y axis runs downwards from the span, so readings below the low end clamp to
      // the largest row, Y_MAX.
      if (y_mean < Y_IN_LO || y_quot == '0) begin
         y_pos = Y_MAX;
      end else if (y_quot >= {1'b0, Y_SPAN}) begin
         y_pos = '0;
      end else begin
         y_pos = Y_SPAN - y_quot[YPosW-1:0];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/tsfs_checker.sv */
// Port-level checker for the touch sample filter and scale unit, with its bind.
`default_nettype none
`include "assert_macros.svh"

module tsfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  rsp_x_pos,
   input logic [7:0]  rsp_y_pos,
   input logic [12:0] rsp_pressure,
   input logic        rsp_touched,
   input logic        rsp_sampled
);

   `TSFS_ASSERT_NXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TSFS_ASSERT_NXT(a_rsp_beat_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_x_pos) && $stable(rsp_y_pos) && $stable(rsp_pressure) && $stable(rsp_touched) && $stable(rsp_sampled))
   `TSFS_ASSERT_IMP(a_empty_output_takes_beat, clock, reset, !rsp_valid, req_ready)
   `TSFS_ASSERT_NXT(a_reset_empties_output, clock, 1'b0, reset, !rsp_valid)

endmodule

bind touch_sample_filter_and_scale_unit tsfs_checker u_tsfs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_x_pos    (rsp_chan.x_pos),
   .rsp_y_pos    (rsp_chan.y_pos),
   .rsp_pressure (rsp_chan.pressure),
   .rsp_touched  (rsp_chan.touched),
   .rsp_sampled  (rsp_chan.sampled)
);

`default_nettype wire
